// ----- hdl/mwm_pkg.sv -----
// Shared constants for the mecanum wheel mixer.
`timescale 1ns / 1ps

package mwm_pkg;

  // Field widths fixed by the command format.
  localparam int CMD_WIDTH = 2;
  localparam int VEL_WIDTH = 17;

  // The mix of three 17-bit velocities needs 19 signed bits.
  localparam int SPEED_MIN_WIDTH = 19;

  // Default compare width and reset value of the compare limit.
  localparam int COMPARE_WIDTH_DEF = 16;
  localparam int MAX_COMPARE_RESET = 999;

  // Number of wheels and their slots in the result arrays.
  localparam int NUM_WHEELS = 4;
  localparam int WHEEL_FL = 0;
  localparam int WHEEL_FR = 1;
  localparam int WHEEL_RL = 2;
  localparam int WHEEL_RR = 3;

  // Command codes. The unused code behaves as coast.
  localparam logic [CMD_WIDTH-1:0] CMD_DRIVE = 2'd0;
  localparam logic [CMD_WIDTH-1:0] CMD_BRAKE = 2'd1;
  localparam logic [CMD_WIDTH-1:0] CMD_COAST = 2'd2;

  // H-bridge pin pair codes: bit 0 is IN1, bit 1 is IN2.
  localparam logic [1:0] PINS_COAST = 2'd0;
  localparam logic [1:0] PINS_FWD   = 2'd1;
  localparam logic [1:0] PINS_REV   = 2'd2;
  localparam logic [1:0] PINS_BRAKE = 2'd3;

endpackage

// ----- hdl/mwm_mix.sv -----
// Mecanum mixing of forward, sideways and turn velocities into four wheel speeds.
`timescale 1ns / 1ps

module mwm_mix #(
  parameter int SPEED_WIDTH = mwm_pkg::SPEED_MIN_WIDTH
) (
  input  logic signed [mwm_pkg::VEL_WIDTH-1:0] vx_i,
  input  logic signed [mwm_pkg::VEL_WIDTH-1:0] vy_i,
  input  logic signed [mwm_pkg::VEL_WIDTH-1:0] turn_rate_i,
  output logic signed [SPEED_WIDTH-1:0]        speed_o [mwm_pkg::NUM_WHEELS]
);

  logic signed [SPEED_WIDTH-1:0] ext_vx;
  logic signed [SPEED_WIDTH-1:0] ext_vy;
  logic signed [SPEED_WIDTH-1:0] ext_w;

  // Sign extend so the sums never wrap.
  assign ext_vx = SPEED_WIDTH'(vx_i);
  assign ext_vy = SPEED_WIDTH'(vy_i);
  assign ext_w  = SPEED_WIDTH'(turn_rate_i);

  // The sideways and turn inputs are negated for the motor wiring; the signs
  // below already include that negation.
  assign speed_o[mwm_pkg::WHEEL_FL] = ext_vx - ext_vy + ext_w;
  assign speed_o[mwm_pkg::WHEEL_FR] = ext_vx + ext_vy - ext_w;
  assign speed_o[mwm_pkg::WHEEL_RL] = ext_vx + ext_vy + ext_w;
  assign speed_o[mwm_pkg::WHEEL_RR] = ext_vx - ext_vy - ext_w;

endmodule

// ----- hdl/mwm_wheel.sv -----
// Clamp of one wheel speed and its encoding into a pin pair and a PWM compare value.
`timescale 1ns / 1ps

module mwm_wheel #(
  parameter int COMPARE_WIDTH = mwm_pkg::COMPARE_WIDTH_DEF,
  parameter int SPEED_WIDTH   = mwm_pkg::SPEED_MIN_WIDTH
) (
  input  logic [mwm_pkg::CMD_WIDTH-1:0] cmd_i,
  input  logic signed [SPEED_WIDTH-1:0] speed_i,
  input  logic [COMPARE_WIDTH-1:0]      max_compare_i,
  output logic [1:0]                    pins_o,
  output logic [COMPARE_WIDTH-1:0]      compare_o
);

  logic [SPEED_WIDTH-1:0]   abs_speed;
  logic [SPEED_WIDTH-1:0]   limit_ext;
  logic                     clip;
  logic [COMPARE_WIDTH-1:0] mag;
  logic [COMPARE_WIDTH:0]   half_sum;
  logic                     is_zero;

  // Magnitude of the raw speed, clamped to the limit.
  assign abs_speed = speed_i[SPEED_WIDTH-1] ? SPEED_WIDTH'(-speed_i) : SPEED_WIDTH'(speed_i);
  assign limit_ext = {{(SPEED_WIDTH-COMPARE_WIDTH){1'b0}}, max_compare_i};
  assign clip      = abs_speed > limit_ext;
  assign mag       = clip ? max_compare_i : abs_speed[COMPARE_WIDTH-1:0];

  // Duty is half way between the clamped magnitude and full scale:
  // floor((limit + mag) / 2).
  assign half_sum  = {1'b0, max_compare_i} + {1'b0, mag};

  // A zero speed counts as zero, and a zero limit clamps every speed to zero.
  assign is_zero   = (speed_i == '0) || (max_compare_i == '0);

  // Decode the command and the speed sign into the pin pair and compare value.
  always_comb begin
    unique case (cmd_i)
      mwm_pkg::CMD_DRIVE: begin
        if (is_zero) begin
          pins_o    = mwm_pkg::PINS_BRAKE;
          compare_o = max_compare_i;
        end else begin
          pins_o    = speed_i[SPEED_WIDTH-1] ? mwm_pkg::PINS_REV : mwm_pkg::PINS_FWD;
          compare_o = half_sum[COMPARE_WIDTH:1];
        end
      end
      mwm_pkg::CMD_BRAKE: begin
        pins_o    = mwm_pkg::PINS_BRAKE;
        compare_o = max_compare_i;
      end
      default: begin
        pins_o    = mwm_pkg::PINS_COAST;
        compare_o = '0;
      end
    endcase
  end

endmodule

// ----- hdl/mecanum_wheel_mixer.sv -----
// Top level of the mecanum wheel mixer: input register, mixing logic and result register.
`timescale 1ns / 1ps

// Usage:
// A command (cmd_i, vx_i, vy_i, turn_rate_i) transfers on the input channel when
// in_valid_i and in_ready_o are both high. Drive mode mixes the velocities into
// four wheel speeds; brake and coast commands set all wheels at once. One result
// with a pin pair and a PWM compare value per wheel transfers on the output
// channel when out_valid_o and out_ready_i are both high.
// A command passes from the input register through the mix, clamp and halving,
// a single combinational stage, into the result register that drives the outputs.
// Throughput: one command per cycle while the receiver does not stall. When it
// stalls, the result register holds and the input register takes a command only
// while it is empty; once it is full, in_ready_o stays low until a transfer.
// The user must write the compare limit with cfg_wr_en_i / cfg_wr_data_i only
// while the block is empty; the block itself does not enforce this. Reset empties
// both registers and sets the limit to 999.
module mecanum_wheel_mixer #(
  parameter int COMPARE_WIDTH = mwm_pkg::COMPARE_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write port.
  input  logic                                 cfg_wr_en_i,
  input  logic [COMPARE_WIDTH-1:0]             cfg_wr_data_i,
  // Command channel.
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [mwm_pkg::CMD_WIDTH-1:0]        cmd_i,
  input  logic signed [mwm_pkg::VEL_WIDTH-1:0] vx_i,
  input  logic signed [mwm_pkg::VEL_WIDTH-1:0] vy_i,
  input  logic signed [mwm_pkg::VEL_WIDTH-1:0] turn_rate_i,
  // Result channel.
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [1:0]                           front_left_pins_o,
  output logic [COMPARE_WIDTH-1:0]             front_left_compare_o,
  output logic [1:0]                           front_right_pins_o,
  output logic [COMPARE_WIDTH-1:0]             front_right_compare_o,
  output logic [1:0]                           rear_left_pins_o,
  output logic [COMPARE_WIDTH-1:0]             rear_left_compare_o,
  output logic [1:0]                           rear_right_pins_o,
  output logic [COMPARE_WIDTH-1:0]             rear_right_compare_o
);

  localparam int SpeedWidth = (COMPARE_WIDTH + 2 > mwm_pkg::SPEED_MIN_WIDTH) ?
                              (COMPARE_WIDTH + 2) : mwm_pkg::SPEED_MIN_WIDTH;
  localparam logic [COMPARE_WIDTH-1:0] MaxCompareReset =
    COMPARE_WIDTH'(mwm_pkg::MAX_COMPARE_RESET);

  logic [COMPARE_WIDTH-1:0] max_compare_q;

  logic                                 s1_valid_q;
  logic                                 s1_ready;
  logic [mwm_pkg::CMD_WIDTH-1:0]        s1_cmd_q;
  logic signed [mwm_pkg::VEL_WIDTH-1:0] s1_vx_q;
  logic signed [mwm_pkg::VEL_WIDTH-1:0] s1_vy_q;
  logic signed [mwm_pkg::VEL_WIDTH-1:0] s1_w_q;

  logic                                 s2_valid_q;
  logic                                 s2_ready;
  logic [1:0]                           pins_d    [mwm_pkg::NUM_WHEELS];
  logic [COMPARE_WIDTH-1:0]             compare_d [mwm_pkg::NUM_WHEELS];
  logic [1:0]                           pins_q    [mwm_pkg::NUM_WHEELS];
  logic [COMPARE_WIDTH-1:0]             compare_q [mwm_pkg::NUM_WHEELS];

  logic signed [SpeedWidth-1:0]         speed     [mwm_pkg::NUM_WHEELS];

  // Compare limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_compare_q <= MaxCompareReset;
    end else if (cfg_wr_en_i) begin
      max_compare_q <= cfg_wr_data_i;
    end
  end

  // Each register takes new data when it is empty or its content moves on.
  assign s2_ready   = !s2_valid_q || out_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  // Input register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_cmd_q <= cmd_i;
      s1_vx_q  <= vx_i;
      s1_vy_q  <= vy_i;
      s1_w_q   <= turn_rate_i;
    end
  end

  // Wheel speed mixing.
  mwm_mix #(
    .SPEED_WIDTH(SpeedWidth)
  ) u_mix (
    .vx_i       (s1_vx_q),
    .vy_i       (s1_vy_q),
    .turn_rate_i(s1_w_q),
    .speed_o    (speed)
  );

  // Per-wheel clamp and output encoding.
  for (genvar k = 0; k < mwm_pkg::NUM_WHEELS; k++) begin : g_wheel
    mwm_wheel #(
      .COMPARE_WIDTH(COMPARE_WIDTH),
      .SPEED_WIDTH  (SpeedWidth)
    ) u_wheel (
      .cmd_i        (s1_cmd_q),
      .speed_i      (speed[k]),
      .max_compare_i(max_compare_q),
      .pins_o       (pins_d[k]),
      .compare_o    (compare_d[k])
    );
  end

  // Result register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      pins_q    <= pins_d;
      compare_q <= compare_d;
    end
  end

  // Output ports.
  assign out_valid_o           = s2_valid_q;
  assign front_left_pins_o     = pins_q[mwm_pkg::WHEEL_FL];
  assign front_left_compare_o  = compare_q[mwm_pkg::WHEEL_FL];
  assign front_right_pins_o    = pins_q[mwm_pkg::WHEEL_FR];
  assign front_right_compare_o = compare_q[mwm_pkg::WHEEL_FR];
  assign rear_left_pins_o      = pins_q[mwm_pkg::WHEEL_RL];
  assign rear_left_compare_o   = compare_q[mwm_pkg::WHEEL_RL];
  assign rear_right_pins_o     = pins_q[mwm_pkg::WHEEL_RR];
  assign rear_right_compare_o  = compare_q[mwm_pkg::WHEEL_RR];

`ifndef SYNTH
  // An accepted command always lands in the input register.
  a_in_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> s1_valid_q)
    else $error("accepted command did not reach the input register");

  // A command blocked by a full result register keeps its contents.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s2_ready |=> s1_valid_q && $stable(s1_cmd_q) && $stable(s1_vx_q))
    else $error("input register changed while stalled");

  // A coasting front left wheel always carries a zero compare value.
  a_coast_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && front_left_pins_o == mwm_pkg::PINS_COAST |-> front_left_compare_o == '0)
    else $error("coast result with nonzero compare");

  // A driven rear right wheel never gets a zero compare value.
  a_drive_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (rear_right_pins_o == mwm_pkg::PINS_FWD ||
                    rear_right_pins_o == mwm_pkg::PINS_REV)
    |-> rear_right_compare_o != '0)
    else $error("driven wheel with zero compare");
`endif

endmodule

// ----- tb/mecanum_wheel_mixer_tb.sv -----
// Self-checking testbench for the mecanum wheel mixer: directed and random commands.
`timescale 1ns / 1ps

module mecanum_wheel_mixer_tb;

  localparam int CW = mwm_pkg::COMPARE_WIDTH_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 4;
  localparam int IDLE_PERCENT = 27;

  // The fourth command code has no name in the package; the block treats it as coast.
  localparam logic [mwm_pkg::CMD_WIDTH-1:0] CMD_UNUSED = 2'd3;

  typedef logic [mwm_pkg::CMD_WIDTH-1:0] cmd_t;
  typedef logic signed [mwm_pkg::VEL_WIDTH-1:0] vel_t;
  localparam vel_t VEL_MAX = vel_t'(65535);
  localparam vel_t VEL_MIN = vel_t'(-65536);

  typedef struct packed {
    logic [1:0]    pins;
    logic [CW-1:0] compare;
  } wheel_drive_t;

  typedef wheel_drive_t [mwm_pkg::NUM_WHEELS-1:0] wheel_set_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_wr_en_i = 1'b0;
  logic [CW-1:0] cfg_wr_data_i = '0;
  logic          in_valid_i = 1'b0;
  logic          in_ready_o;
  cmd_t          cmd_i = mwm_pkg::CMD_COAST;
  vel_t          vx_i = '0;
  vel_t          vy_i = '0;
  vel_t          turn_rate_i = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  logic [1:0]    front_left_pins_o;
  logic [CW-1:0] front_left_compare_o;
  logic [1:0]    front_right_pins_o;
  logic [CW-1:0] front_right_compare_o;
  logic [1:0]    rear_left_pins_o;
  logic [CW-1:0] rear_left_compare_o;
  logic [1:0]    rear_right_pins_o;
  logic [CW-1:0] rear_right_compare_o;

  // Testbench copy of the compare limit and the wheel sets still owed by the block.
  logic [CW-1:0] compare_limit = CW'(mwm_pkg::MAX_COMPARE_RESET);
  wheel_set_t    pending_wheel_sets[$];
  int unsigned   error_count = 0;
  int unsigned   cycle_count = 0;
  bit            steady_flow = 1'b0;
  string         wheel_label[mwm_pkg::NUM_WHEELS] = '{"front_left", "front_right",
                                                      "rear_left", "rear_right"};

  mecanum_wheel_mixer #(
    .COMPARE_WIDTH(CW)
  ) dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_wr_en_i           (cfg_wr_en_i),
    .cfg_wr_data_i         (cfg_wr_data_i),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .cmd_i                 (cmd_i),
    .vx_i                  (vx_i),
    .vy_i                  (vy_i),
    .turn_rate_i           (turn_rate_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .front_left_pins_o     (front_left_pins_o),
    .front_left_compare_o  (front_left_compare_o),
    .front_right_pins_o    (front_right_pins_o),
    .front_right_compare_o (front_right_compare_o),
    .rear_left_pins_o      (rear_left_pins_o),
    .rear_left_compare_o   (rear_left_compare_o),
    .rear_right_pins_o     (rear_right_pins_o),
    .rear_right_compare_o  (rear_right_compare_o)
  );

  // Clock generation.
  initial begin
    forever begin
      #5 clk_i = ~clk_i;
    end
  end

  // Cycle counter and watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Clamp one wheel speed and turn it into a pin pair and a compare value.
  function automatic wheel_drive_t wheel_for_speed(input int speed, input logic [CW-1:0] limit);
    int           lim;
    int           s;
    int           mag;
    wheel_drive_t d;
    lim = int'(limit);
    s = speed;
    if (s > lim) s = lim;
    if (s < -lim) s = -lim;
    if (s == 0) begin
      d.pins = mwm_pkg::PINS_BRAKE;
      d.compare = limit;
    end else begin
      d.pins = (s > 0) ? mwm_pkg::PINS_FWD : mwm_pkg::PINS_REV;
      mag = (s > 0) ? s : -s;
      d.compare = CW'((lim + mag) / 2);
    end
    return d;
  endfunction

  // Expected wheel set for one command under the given compare limit.
  function automatic wheel_set_t predict_wheels(input cmd_t cmd, input vel_t vx,
                                                input vel_t vy, input vel_t turn,
                                                input logic [CW-1:0] limit);
    int         fwd;
    int         side;
    int         rot;
    wheel_set_t r;
    r = '0;
    case (cmd)
      mwm_pkg::CMD_DRIVE: begin
        // Sideways and turn are inverted by the wiring before the mix.
        fwd = int'(vx);
        side = -int'(vy);
        rot = -int'(turn);
        r[mwm_pkg::WHEEL_FL] = wheel_for_speed(fwd + side - rot, limit);
        r[mwm_pkg::WHEEL_FR] = wheel_for_speed(fwd - side + rot, limit);
        r[mwm_pkg::WHEEL_RL] = wheel_for_speed(fwd - side - rot, limit);
        r[mwm_pkg::WHEEL_RR] = wheel_for_speed(fwd + side + rot, limit);
      end
      mwm_pkg::CMD_BRAKE: begin
        for (int k = 0; k < mwm_pkg::NUM_WHEELS; k++) begin
          r[k].pins = mwm_pkg::PINS_BRAKE;
          r[k].compare = limit;
        end
      end
      default: begin
        for (int k = 0; k < mwm_pkg::NUM_WHEELS; k++) begin
          r[k].pins = mwm_pkg::PINS_COAST;
          r[k].compare = '0;
        end
      end
    endcase
    return r;
  endfunction

  // Receiver side: stall at random unless a steady stretch is running.
  always @(posedge clk_i) begin
    out_ready_i <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
  end

  task automatic check_field(input string name, input int unsigned expected,
                             input int unsigned actual);
    if (expected != actual) begin
      $error("%s: expected %0d, got %0d", name, expected, actual);
      error_count++;
    end
  endtask

  // Result checker: each result transfer is matched against the oldest expectation.
  always @(posedge clk_i) begin
    wheel_set_t expected;
    wheel_set_t actual;
    if (rst_ni && out_valid_o && out_ready_i) begin
      actual[mwm_pkg::WHEEL_FL] = '{pins: front_left_pins_o, compare: front_left_compare_o};
      actual[mwm_pkg::WHEEL_FR] = '{pins: front_right_pins_o, compare: front_right_compare_o};
      actual[mwm_pkg::WHEEL_RL] = '{pins: rear_left_pins_o, compare: rear_left_compare_o};
      actual[mwm_pkg::WHEEL_RR] = '{pins: rear_right_pins_o, compare: rear_right_compare_o};
      if (pending_wheel_sets.size() == 0) begin
        $error("result transfer with no command outstanding");
        error_count++;
      end else begin
        expected = pending_wheel_sets.pop_front();
        for (int k = 0; k < mwm_pkg::NUM_WHEELS; k++) begin
          check_field({wheel_label[k], "_pins"}, expected[k].pins, actual[k].pins);
          check_field({wheel_label[k], "_compare"}, expected[k].compare, actual[k].compare);
        end
      end
    end
  end

  // Send one command; the expectation is queued at the edge of the transfer.
  task automatic send_command(input cmd_t cmd, input vel_t vx, input vel_t vy,
                              input vel_t turn);
    while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    vx_i <= vx;
    vy_i <= vy;
    turn_rate_i <= turn;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    pending_wheel_sets.push_back(predict_wheels(cmd, vx, vy, turn, compare_limit));
  endtask

  // Stop sending and wait until every outstanding result has transferred.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (pending_wheel_sets.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Change the compare limit once the block is empty.
  task automatic write_compare_limit(input logic [CW-1:0] value);
    wait_for_results();
    cfg_wr_en_i <= 1'b1;
    cfg_wr_data_i <= value;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    compare_limit = value;
  endtask

  // Random velocity: full range, near the limit, zero or an extreme.
  function automatic vel_t rand_velocity(input int limit);
    int span;
    span = limit / 2 + 2;
    case ($urandom_range(3))
      0: return vel_t'($urandom);
      1: return vel_t'(int'($urandom_range(0, 2 * span)) - span);
      2: return '0;
      default: return $urandom_range(1) ? VEL_MAX : VEL_MIN;
    endcase
  endfunction

  function automatic cmd_t rand_command();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return mwm_pkg::CMD_DRIVE;
    if (r < 88) return mwm_pkg::CMD_BRAKE;
    if (r < 95) return mwm_pkg::CMD_COAST;
    return CMD_UNUSED;
  endfunction

  // Directed commands under the reset limit: each mode, extremes and zero wheel speeds.
  task automatic test_reset_limit();
    send_command(mwm_pkg::CMD_DRIVE, '0, '0, '0);
    send_command(mwm_pkg::CMD_DRIVE, vel_t'(100), '0, '0);
    send_command(mwm_pkg::CMD_DRIVE, vel_t'(-101), '0, '0);
    send_command(mwm_pkg::CMD_DRIVE, VEL_MAX, '0, '0);
    send_command(mwm_pkg::CMD_DRIVE, VEL_MIN, '0, '0);
    send_command(mwm_pkg::CMD_DRIVE, VEL_MAX, VEL_MIN, VEL_MAX);
    send_command(mwm_pkg::CMD_DRIVE, VEL_MIN, VEL_MAX, VEL_MIN);
    send_command(mwm_pkg::CMD_DRIVE, VEL_MAX, VEL_MAX, VEL_MAX);
    send_command(mwm_pkg::CMD_DRIVE, VEL_MIN, VEL_MIN, VEL_MIN);
    // Front left and rear right cancel to zero here.
    send_command(mwm_pkg::CMD_DRIVE, vel_t'(5), vel_t'(5), '0);
    send_command(mwm_pkg::CMD_DRIVE, '0, '0, vel_t'(7));
    send_command(mwm_pkg::CMD_DRIVE, '0, vel_t'(-300), '0);
    send_command(mwm_pkg::CMD_BRAKE, vel_t'(400), vel_t'(-3), vel_t'(12));
    send_command(mwm_pkg::CMD_COAST, VEL_MAX, VEL_MAX, VEL_MAX);
    send_command(CMD_UNUSED, vel_t'(250), '0, '0);
  endtask

  // Directed commands at the largest limit, a zero limit and a limit of one.
  task automatic test_limit_extremes();
    write_compare_limit('1);
    send_command(mwm_pkg::CMD_DRIVE, VEL_MAX, VEL_MIN, VEL_MAX);
    send_command(mwm_pkg::CMD_DRIVE, vel_t'(1), '0, '0);
    send_command(mwm_pkg::CMD_BRAKE, '0, '0, '0);
    // With a zero limit every speed clamps to zero.
    write_compare_limit('0);
    send_command(mwm_pkg::CMD_DRIVE, VEL_MAX, VEL_MIN, VEL_MAX);
    send_command(mwm_pkg::CMD_BRAKE, VEL_MIN, '0, '0);
    write_compare_limit(CW'(1));
    send_command(mwm_pkg::CMD_DRIVE, vel_t'(1), '0, '0);
    send_command(mwm_pkg::CMD_DRIVE, vel_t'(-1), '0, vel_t'(1));
  endtask

  // Random commands with idling on both sides under one limit.
  task automatic test_random_commands(input int count, input logic [CW-1:0] limit);
    write_compare_limit(limit);
    for (int n = 0; n < count; n++) begin
      send_command(rand_command(), rand_velocity(int'(limit)), rand_velocity(int'(limit)),
                   rand_velocity(int'(limit)));
    end
  endtask

  // Back-to-back transfers with no idling on either side.
  task automatic test_steady_stream(input int count, input logic [CW-1:0] limit);
    write_compare_limit(limit);
    steady_flow = 1'b1;
    for (int n = 0; n < count; n++) begin
      send_command(rand_command(), rand_velocity(int'(limit)), rand_velocity(int'(limit)),
                   rand_velocity(int'(limit)));
    end
    steady_flow = 1'b0;
  endtask

  // Test sequence.
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_limit();
    test_limit_extremes();
    test_random_commands(250, CW'($urandom_range(1, 40)));
    test_random_commands(250, '1);
    test_random_commands(250, CW'($urandom_range(1, 65535)));
    test_random_commands(250, CW'(1));
    test_steady_stream(350, CW'($urandom_range(100, 5000)));
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
